>>> sv/mwo_pkg.sv
package mwo_pkg;

    localparam int KMER_LEN = 31;
    localparam int MMER_LEN = 15;
    localparam int WIN = (KMER_LEN > MMER_LEN) ? (KMER_LEN - MMER_LEN + 1) : 1;

    localparam int HASH_W = 64;
    localparam int OWNER_W = 16;
    localparam int FILL_W = 6;
    localparam int REM_W = OWNER_W + 1;

    localparam int CNT_MAX = (WIN > HASH_W) ? WIN : HASH_W;
    localparam int CNT_W = $clog2(CNT_MAX + 1);

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WIN - 1);
    localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(WIN - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(HASH_W - 1);
    localparam logic [OWNER_W-1:0] OWNER_COUNT_RESET = OWNER_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LOAD,
        ST_DIV,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic first;
    } win_ctrl_t;

    typedef struct packed {
        logic load;
        logic step;
    } div_ctrl_t;

endpackage

>>> sv/mwo_window.sv
module mwo_window (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mwo_pkg::win_ctrl_t           ctrl,
    input  logic [mwo_pkg::HASH_W-1:0]   hash,
    output logic [mwo_pkg::HASH_W-1:0]   min_hash
);

    logic [mwo_pkg::HASH_W-1:0] win_reg [mwo_pkg::WIN];
    logic [mwo_pkg::HASH_W-1:0] win_next [mwo_pkg::WIN];
    logic [mwo_pkg::HASH_W-1:0] min_reg;
    logic [mwo_pkg::HASH_W-1:0] min_next;
    logic [mwo_pkg::HASH_W-1:0] tail;

    assign tail = win_reg[mwo_pkg::WIN-1];

    // During a scan the window rotates once per cycle, so the oldest entry
    // passes the comparator and all entries are back in place after the pass.
    always_comb
    begin
        for (int i = 0; i < mwo_pkg::WIN; i++)
        begin
            win_next[i] = win_reg[i];
        end
        if (ctrl.load || ctrl.scan)
        begin
            win_next[0] = ctrl.load ? hash : tail;
            for (int i = 1; i < mwo_pkg::WIN; i++)
            begin
                win_next[i] = win_reg[i-1];
            end
        end
    end

    always_comb
    begin
        min_next = min_reg;
        if (ctrl.scan)
        begin
            if (ctrl.first || (tail < min_reg))
            begin
                min_next = tail;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mwo_pkg::WIN; i++)
            begin
                win_reg[i] <= '0;
            end
            min_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < mwo_pkg::WIN; i++)
            begin
                win_reg[i] <= win_next[i];
            end
            min_reg <= min_next;
        end
    end

    assign min_hash = min_reg;

endmodule

>>> sv/mwo_divider.sv
module mwo_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mwo_pkg::div_ctrl_t            ctrl,
    input  logic [mwo_pkg::HASH_W-1:0]    dividend,
    input  logic [mwo_pkg::OWNER_W-1:0]   divisor,
    output logic [mwo_pkg::OWNER_W-1:0]   remainder
);

    logic [mwo_pkg::REM_W-1:0]   rem_reg;
    logic [mwo_pkg::REM_W-1:0]   rem_next;
    logic [mwo_pkg::HASH_W-1:0]  dvd_reg;
    logic [mwo_pkg::HASH_W-1:0]  dvd_next;
    logic [mwo_pkg::OWNER_W-1:0] dsr_reg;
    logic [mwo_pkg::OWNER_W-1:0] dsr_next;
    logic [mwo_pkg::REM_W-1:0]   trial;

    // Restoring division, one dividend bit per step. A zero divisor never
    // subtracts anything, so the low bits of the dividend remain.
    assign trial = {rem_reg[mwo_pkg::OWNER_W-1:0], dvd_reg[mwo_pkg::HASH_W-1]};

    always_comb
    begin
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        dsr_next = dsr_reg;
        if (ctrl.load)
        begin
            rem_next = '0;
            dvd_next = dividend;
            dsr_next = divisor;
        end
        else if (ctrl.step)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = trial - {1'b0, dsr_reg};
            end
            else
            begin
                rem_next = trial;
            end
            dvd_next = {dvd_reg[mwo_pkg::HASH_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            dvd_reg <= '0;
            dsr_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
            dsr_reg <= dsr_next;
        end
    end

    assign remainder = rem_reg[mwo_pkg::OWNER_W-1:0];

endmodule

>>> sv/minimizer_window_owner_core.sv
// Minimizer owner: each request carries one m-mer hash and a read start flag.
// The first KMER_LEN-MMER_LEN hashes of a read only fill the window and are
// accepted without leaving idle, with no result. For every later request the
// rotating window (WIN = KMER_LEN-MMER_LEN+1 entries) passes one entry a cycle
// through the single 64-bit comparator; then the divider is loaded and the
// bit-serial remainder by owner_count is formed, after which the owner is held
// until taken. No new request is accepted while one is in progress or its
// result waits. An owner_count of zero returns the low 16 bits of the minimum
// hash. Write owner_count only while the block is idle.
module minimizer_window_owner_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [mwo_pkg::OWNER_W-1:0]   cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [mwo_pkg::HASH_W-1:0]    mmer_hash,
    input  logic                          read_start,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mwo_pkg::OWNER_W-1:0]   owner
);

    mwo_pkg::state_t             state_reg;
    mwo_pkg::state_t             state_next;
    logic [mwo_pkg::CNT_W-1:0]   cnt_reg;
    logic [mwo_pkg::CNT_W-1:0]   cnt_next;
    logic [mwo_pkg::FILL_W-1:0]  fill_reg;
    logic [mwo_pkg::FILL_W-1:0]  fill_next;
    logic [mwo_pkg::FILL_W-1:0]  fill_base;
    logic [mwo_pkg::OWNER_W-1:0] owner_count_reg;
    logic [mwo_pkg::HASH_W-1:0]  min_hash;
    logic                        accept;
    logic                        filling;
    mwo_pkg::win_ctrl_t          win_ctrl;
    mwo_pkg::div_ctrl_t          div_ctrl;

    assign accept = in_valid && !in_stall;
    assign fill_base = read_start ? '0 : fill_reg;
    assign filling = fill_base < mwo_pkg::FILL_FULL;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mwo_pkg::ST_IDLE:
            begin
                if (accept && !filling)
                begin
                    state_next = mwo_pkg::ST_SCAN;
                end
            end
            mwo_pkg::ST_SCAN:
            begin
                if (cnt_reg == mwo_pkg::SCAN_LAST)
                begin
                    state_next = mwo_pkg::ST_LOAD;
                end
            end
            mwo_pkg::ST_LOAD:
            begin
                state_next = mwo_pkg::ST_DIV;
            end
            mwo_pkg::ST_DIV:
            begin
                if (cnt_reg == mwo_pkg::DIV_LAST)
                begin
                    state_next = mwo_pkg::ST_HOLD;
                end
            end
            mwo_pkg::ST_HOLD:
            begin
                if (!out_stall)
                begin
                    state_next = mwo_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mwo_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        out_valid = 1'b0;
        win_ctrl = '0;
        div_ctrl = '0;
        cnt_next = '0;
        fill_next = fill_reg;
        case (state_reg)
            mwo_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (accept)
                begin
                    win_ctrl.load = 1'b1;
                    fill_next = filling ? fill_base + 1'b1 : fill_base;
                end
            end
            mwo_pkg::ST_SCAN:
            begin
                win_ctrl.scan = 1'b1;
                win_ctrl.first = (cnt_reg == '0);
                cnt_next = cnt_reg + 1'b1;
            end
            mwo_pkg::ST_LOAD:
            begin
                div_ctrl.load = 1'b1;
            end
            mwo_pkg::ST_DIV:
            begin
                div_ctrl.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
            mwo_pkg::ST_HOLD:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mwo_pkg::ST_IDLE;
            cnt_reg <= '0;
            fill_reg <= '0;
            owner_count_reg <= mwo_pkg::OWNER_COUNT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            fill_reg <= fill_next;
            if (cfg_wr_en)
            begin
                owner_count_reg <= cfg_wr_data;
            end
        end
    end

    mwo_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (win_ctrl),
        .hash     (mmer_hash),
        .min_hash (min_hash)
    );

    mwo_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .dividend  (min_hash),
        .divisor   (owner_count_reg),
        .remainder (owner)
    );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    typedef struct {
        logic [mwo_pkg::HASH_W-1:0] hash;
        logic                       start;
    } mmer_req_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [mwo_pkg::OWNER_W-1:0]   cfg_wr_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [mwo_pkg::HASH_W-1:0]    mmer_hash = '0;
    logic                          read_start = 1'b0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [mwo_pkg::OWNER_W-1:0]   owner;

    mmer_req_t                     pending_reqs[$];
    logic [mwo_pkg::OWNER_W-1:0]   owner_expected[$];
    mmer_req_t                     next_req;
    logic [mwo_pkg::HASH_W-1:0]    win_hash[mwo_pkg::WIN];
    logic [mwo_pkg::FILL_W-1:0]    fill_cnt = '0;
    logic [mwo_pkg::OWNER_W-1:0]   owner_div = mwo_pkg::OWNER_COUNT_RESET;
    int                            send_gap = 0;
    int                            stall_left = 0;
    int                            failures = 0;
    logic                          calm = 1'b0;

    minimizer_window_owner_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mmer_hash   (mmer_hash),
        .read_start  (read_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .owner       (owner)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic add_req(input logic [mwo_pkg::HASH_W-1:0] h, input logic s);
        mmer_req_t r;
        r.hash = h;
        r.start = s;
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    task automatic take_mmer(input logic [mwo_pkg::HASH_W-1:0] h, input logic s);
        logic [mwo_pkg::HASH_W-1:0] lowest;
        if (s)
        begin
            fill_cnt = '0;
        end
        for (int i = mwo_pkg::WIN - 1; i > 0; i--)
        begin
            win_hash[i] = win_hash[i-1];
        end
        win_hash[0] = h;
        if (fill_cnt < mwo_pkg::FILL_FULL)
        begin
            fill_cnt = fill_cnt + 1'b1;
            return;
        end
        lowest = win_hash[0];
        for (int i = 1; i < mwo_pkg::WIN; i++)
        begin
            if (win_hash[i] < lowest)
            begin
                lowest = win_hash[i];
            end
        end
        if (owner_div == '0)
        begin
            owner_expected.insert(owner_expected.size(), lowest[mwo_pkg::OWNER_W-1:0]);
        end
        else
        begin
            owner_expected.insert(owner_expected.size(),
                mwo_pkg::OWNER_W'(lowest % mwo_pkg::HASH_W'(owner_div)));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            mmer_hash <= '0;
            read_start <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                take_mmer(mmer_hash, read_start);
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap != 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_reqs.size() != 0)
                begin
                    next_req = pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    mmer_hash <= next_req.hash;
                    read_start <= next_req.start;
                    if (!calm && $urandom_range(0, 7) == 0)
                    begin
                        send_gap <= $urandom_range(1, 11);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (owner_expected.size() == 0)
                begin
                    $error("owner: unexpected result, actual %0d", owner);
                    failures++;
                end
                else if (owner !== owner_expected[0])
                begin
                    $error("owner mismatch: expected %0d, actual %0d",
                           owner_expected[0], owner);
                    failures++;
                    void'(owner_expected.pop_front());
                end
                else
                begin
                    void'(owner_expected.pop_front());
                end
            end
            if (stall_left != 0)
            begin
                out_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else if (!calm && $urandom_range(0, 11) == 0)
            begin
                out_stall <= 1'b1;
                stall_left <= $urandom_range(0, 10);
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    function automatic logic [mwo_pkg::HASH_W-1:0] pick_hash(
        input logic [mwo_pkg::HASH_W-1:0] prev
    );
        case ($urandom_range(0, 9))
            0: pick_hash = prev;
            1: pick_hash = mwo_pkg::HASH_W'($urandom_range(0, 300));
            2: pick_hash = '1;
            3: pick_hash = {32'hFFFF_FFFF, 32'($urandom)};
            4: pick_hash = '0;
            default: pick_hash = {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    task automatic queue_reads(input int n_items);
        int                         len;
        int                         made;
        logic [mwo_pkg::HASH_W-1:0] h;
        made = 0;
        h = '0;
        while (made < n_items)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                len = $urandom_range(1, mwo_pkg::WIN - 1);
            end
            else
            begin
                len = $urandom_range(mwo_pkg::WIN, 3 * mwo_pkg::WIN);
            end
            if (len > n_items - made)
            begin
                len = n_items - made;
            end
            for (int k = 0; k < len; k++)
            begin
                h = pick_hash(h);
                add_req(h, (k == 0) && ($urandom_range(0, 9) != 0));
            end
            made += len;
        end
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || in_valid || owner_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (mwo_pkg::WIN + 100) @(posedge clk);
    endtask

    task automatic set_owner_count(input logic [mwo_pkg::OWNER_W-1:0] value);
        wait_idle();
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        owner_div = value;
    endtask

    initial
    begin
        logic [mwo_pkg::OWNER_W-1:0] phase_counts[10];
        phase_counts = '{16'hFFFF, 16'd1, 16'd2, 16'd3, 16'd0,
                         mwo_pkg::OWNER_W'($urandom_range(1, 65535)), 16'hFFFE, 16'd256,
                         mwo_pkg::OWNER_W'($urandom_range(1, 65535)),
                         mwo_pkg::OWNER_W'($urandom_range(4, 64))};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // With no read start after reset, hashes belong to one read begun at reset.
        add_req('0, 1'b0);
        add_req('1, 1'b0);
        for (int k = 0; k < 15; k++)
        begin
            add_req({32'($urandom), 32'($urandom)}, 1'b0);
        end

        // A short read gives nothing; equal maximal hashes tie inside the window.
        set_owner_count(16'd0);
        add_req(64'd5, 1'b1);
        add_req(64'd7, 1'b0);
        for (int k = 0; k < mwo_pkg::WIN; k++)
        begin
            add_req('1, (k == 0));
        end
        add_req(64'h0000_0000_0001_2345, 1'b0);

        for (int p = 0; p < 10; p++)
        begin
            set_owner_count(phase_counts[p]);
            if (p == 9)
            begin
                calm = 1'b1;
            end
            queue_reads(195);
        end

        wait_idle();
        repeat (mwo_pkg::WIN + 100) @(posedge clk);
        if (failures == 0 && owner_expected.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
